### rtl/core/lsi_pkg.sv
package lsi_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int MIN_SWAP    = 2;
  localparam int DATA_W      = 32;
  localparam int LINE_W      = 32;

  // Request codes as they arrive on the input channel
  localparam logic [2:0] REQ_PUSH = 3'd0;
  localparam logic [2:0] REQ_DUMP = 3'd1;
  localparam logic [2:0] REQ_PEEK = 3'd2;
  localparam logic [2:0] REQ_POP  = 3'd3;
  localparam logic [2:0] REQ_SWAP = 3'd4;

  // Status codes on the result channel
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_SHORT = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_HALT  = 3'd4;

  // Decoded operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_DUMP,
    OP_PEEK,
    OP_POP,
    OP_SWAP,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [DATA_W-1:0]  value;
    logic [LINE_W-1:0]         line;
  } cmd_t;

endpackage

### rtl/core/lsi_if.sv
interface lsi_in_if;
  import lsi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [2:0]                req_type;
  logic signed [DATA_W-1:0]  push_value;
  logic [LINE_W-1:0]         script_line;

  modport source (output valid, output req_type, output push_value, output script_line,
                  input ready);
  modport sink   (input valid, input req_type, input push_value, input script_line,
                  output ready);
endinterface

interface lsi_out_if;
  import lsi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  data;
  logic                      has_data;
  logic [2:0]                status;
  logic [LINE_W-1:0]         error_line;
  logic                      last;

  modport source (output valid, output data, output has_data, output status,
                  output error_line, output last, input ready);
  modport sink   (input valid, input data, input has_data, input status,
                  input error_line, input last, output ready);
endinterface

### rtl/core/lsi_ram.sv
module lsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/lsi_front.sv
module lsi_front (
  input  logic          clk,
  input  logic          rst_n,
  lsi_in_if.sink        in_ch,
  output lsi_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_take
);
  import lsi_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  cmd_t       dec;
  logic       push_q;
  logic       pop_q;

  // Classify the incoming word
  always_comb begin
    dec.value = in_ch.push_value;
    dec.line  = in_ch.script_line;
    unique case (in_ch.req_type)
      REQ_PUSH: dec.op = OP_PUSH;
      REQ_DUMP: dec.op = OP_DUMP;
      REQ_PEEK: dec.op = OP_PEEK;
      REQ_POP:  dec.op = OP_POP;
      REQ_SWAP: dec.op = OP_SWAP;
      default:  dec.op = OP_NOP;
    endcase
  end

  assign in_ch.ready = (fill_r != 2'd2);
  assign push_q      = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (fill_r != 2'd0);
  assign pop_q       = cmd_valid && cmd_take;
  assign cmd         = q_r[rd_ptr_r];

  // Two-entry command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push_q) begin
        q_r[wr_ptr_r] <= dec;
        wr_ptr_r      <= ~wr_ptr_r;
      end
      if (pop_q) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push_q, pop_q})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

endmodule

### rtl/core/lsi_back.sv
module lsi_back (
  input  logic          clk,
  input  logic          rst_n,
  input  lsi_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_take,
  lsi_out_if.source     out_ch
);
  import lsi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEEK,
    S_DUMP,
    S_SWAP1,
    S_SWAP2,
    S_SWAP3
  } state_t;

  state_t                    state_r;
  state_t                    state_nxt;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      halted_r;
  logic                      halted_nxt;
  logic [ADDR_W-1:0]         idx_r;
  logic [ADDR_W-1:0]         idx_nxt;
  logic [DATA_W-1:0]         tmp_r;
  logic [DATA_W-1:0]         tmp_nxt;

  logic                      out_v_r;
  logic                      out_v_nxt;
  logic signed [DATA_W-1:0]  data_r;
  logic signed [DATA_W-1:0]  data_nxt;
  logic                      has_r;
  logic                      has_nxt;
  logic [2:0]                status_r;
  logic [2:0]                status_nxt;
  logic [LINE_W-1:0]         eline_r;
  logic [LINE_W-1:0]         eline_nxt;
  logic                      last_r;
  logic                      last_nxt;

  logic                      out_free;
  logic                      full;
  logic                      empty;
  logic                      short;
  logic [CNT_W-1:0]          count_m1;
  logic [ADDR_W-1:0]         top_addr;
  logic [ADDR_W-1:0]         below_addr;

  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_waddr;
  logic [DATA_W-1:0]         ram_wdata;
  logic                      ram_re;
  logic [ADDR_W-1:0]         ram_raddr;
  logic [DATA_W-1:0]         ram_rdata;

  assign out_free   = !out_v_r || out_ch.ready;
  assign full       = (count_r >= CNT_W'(STACK_DEPTH));
  assign empty      = (count_r == '0);
  assign short      = (count_r < CNT_W'(MIN_SWAP));
  assign count_m1   = count_r - CNT_W'(1);
  assign top_addr   = count_m1[ADDR_W-1:0];
  assign below_addr = top_addr - ADDR_W'(1);
  assign cmd_take   = (state_r == S_IDLE) && out_free;

  assign out_ch.valid      = out_v_r;
  assign out_ch.data       = data_r;
  assign out_ch.has_data   = has_r;
  assign out_ch.status     = status_r;
  assign out_ch.error_line = eline_r;
  assign out_ch.last       = last_r;

  // Drive the stack memory ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = top_addr;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = top_addr;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free && !halted_r) begin
          unique case (cmd.op)
            OP_PUSH: begin
              ram_we    = !full;
              ram_waddr = count_r[ADDR_W-1:0];
              ram_wdata = cmd.value;
            end
            OP_DUMP, OP_PEEK: ram_re = !empty;
            OP_SWAP:          ram_re = !short;
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        ram_re    = out_free && (idx_r != '0);
        ram_raddr = idx_r - ADDR_W'(1);
      end
      S_SWAP1: begin
        ram_re    = 1'b1;
        ram_raddr = below_addr;
      end
      S_SWAP2: begin
        ram_we    = 1'b1;
        ram_waddr = top_addr;
        ram_wdata = ram_rdata;
      end
      S_SWAP3: begin
        ram_we    = out_free;
        ram_waddr = below_addr;
        ram_wdata = tmp_r;
      end
      default: ;
    endcase
  end

  lsi_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Sequence commands, update stack state, build the next result word
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    halted_nxt = halted_r;
    idx_nxt    = idx_r;
    tmp_nxt    = tmp_r;
    out_v_nxt  = out_v_r && !out_ch.ready;
    data_nxt   = data_r;
    has_nxt    = has_r;
    status_nxt = status_r;
    eline_nxt  = eline_r;
    last_nxt   = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          // default result: ok, single, no data
          out_v_nxt  = 1'b1;
          data_nxt   = '0;
          has_nxt    = 1'b0;
          status_nxt = ST_OK;
          eline_nxt  = '0;
          last_nxt   = 1'b1;
          if (halted_r) begin
            status_nxt = ST_HALT;
          end else begin
            unique case (cmd.op)
              OP_PUSH: begin
                if (full) begin
                  status_nxt = ST_FULL;
                  eline_nxt  = cmd.line;
                end else begin
                  count_nxt = count_r + CNT_W'(1);
                end
              end
              OP_DUMP: begin
                if (!empty) begin
                  out_v_nxt = 1'b0;
                  idx_nxt   = top_addr;
                  state_nxt = S_DUMP;
                end
              end
              OP_PEEK: begin
                if (empty) begin
                  halted_nxt = 1'b1;
                  status_nxt = ST_EMPTY;
                  eline_nxt  = cmd.line;
                end else begin
                  out_v_nxt = 1'b0;
                  state_nxt = S_PEEK;
                end
              end
              OP_POP: begin
                if (empty) begin
                  halted_nxt = 1'b1;
                  status_nxt = ST_EMPTY;
                  eline_nxt  = cmd.line;
                end else begin
                  count_nxt = count_m1;
                end
              end
              OP_SWAP: begin
                if (short) begin
                  halted_nxt = 1'b1;
                  status_nxt = ST_SHORT;
                  eline_nxt  = cmd.line;
                end else begin
                  out_v_nxt = 1'b0;
                  state_nxt = S_SWAP1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_PEEK: begin
        if (out_free) begin
          out_v_nxt  = 1'b1;
          data_nxt   = ram_rdata;
          has_nxt    = 1'b1;
          status_nxt = ST_OK;
          eline_nxt  = '0;
          last_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DUMP: begin
        // emit one entry per word, top first
        if (out_free) begin
          out_v_nxt  = 1'b1;
          data_nxt   = ram_rdata;
          has_nxt    = 1'b1;
          status_nxt = ST_OK;
          eline_nxt  = '0;
          last_nxt   = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r - ADDR_W'(1);
          end
        end
      end
      S_SWAP1: begin
        tmp_nxt   = ram_rdata;
        state_nxt = S_SWAP2;
      end
      S_SWAP2: begin
        state_nxt = S_SWAP3;
      end
      S_SWAP3: begin
        if (out_free) begin
          out_v_nxt  = 1'b1;
          data_nxt   = '0;
          has_nxt    = 1'b0;
          status_nxt = ST_OK;
          eline_nxt  = '0;
          last_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      halted_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
      out_v_r  <= out_v_nxt;
    end
    idx_r    <= idx_nxt;
    tmp_r    <= tmp_nxt;
    data_r   <= data_nxt;
    has_r    <= has_nxt;
    status_r <= status_nxt;
    eline_r  <= eline_nxt;
    last_r   <= last_nxt;
  end

endmodule

### rtl/core/lifo_stack_interpreter_ops.sv
// Channel | Dir | Payload                                       | Handshake
// in_ch   | in  | req_type, push_value, script_line             | valid/ready
// out_ch  | out | data, has_data, status, error_line, last      | valid/ready
//
// A word is registered in the two-entry command queue before execution.
// Push, pop, halted and error words need no memory read; peek reads the top
// first; swap makes two reads and two writes on the stack memory; dump gives
// one result per entry. Reset clears the entry count, the halt flag, the
// command queue and the result valid; the stack memory is not cleared.
// While the back stalls on out_ch, the front accepts until the queue is full.
module lifo_stack_interpreter_ops (
  input  logic      clk,
  input  logic      rst_n,
  lsi_in_if.sink    in_ch,
  lsi_out_if.source out_ch
);
  import lsi_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  lsi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  lsi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .out_ch    (out_ch)
  );

endmodule

### rtl/core/lsi_checker.sv
module lsi_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [lsi_pkg::DATA_W-1:0] out_data,
  input logic                             out_has_data,
  input logic [2:0]                       out_status,
  input logic [lsi_pkg::LINE_W-1:0]       out_error_line,
  input logic                             out_last
);
  import lsi_pkg::*;

  // Nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_status))
    else $error("stalled result changed");

  // Only error results carry a line number
  a_eline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK || out_status == ST_HALT) |-> out_error_line == '0)
    else $error("error line on non-error result");

  // Data only on ok results
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_data |-> out_status == ST_OK)
    else $error("data on failing result");

  // Halted results are single and empty
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_HALT |-> out_last && !out_has_data && out_data == '0)
    else $error("malformed halted result");

endmodule

bind lifo_stack_interpreter_ops lsi_checker u_lsi_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_data       (out_ch.data),
  .out_has_data   (out_ch.has_data),
  .out_status     (out_ch.status),
  .out_error_line (out_ch.error_line),
  .out_last       (out_ch.last)
);

### sim/lsi_stack_checker.sv
module lsi_stack_checker (
  input  logic clk,
  input  logic rst_n,
  lsi_in_if    in_mon,
  lsi_out_if   out_mon,
  output int   fail_count,
  output int   pending,
  output int   words_in,
  output int   words_out,
  output int   peak_depth,
  output int   overflow_cnt,
  output bit   halt_seen
);
  import lsi_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     has_data;
    logic [2:0]               status;
    logic [LINE_W-1:0]        error_line;
    logic                     last;
  } stack_reply_t;

  // Shadow copy of the stack and the sticky halt
  logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH];
  int                       depth;
  bit                       halted;
  stack_reply_t             reply_q [$];

  function automatic stack_reply_t make_reply(logic signed [DATA_W-1:0] d, logic hd,
                                              logic [2:0] st, logic [LINE_W-1:0] ln,
                                              logic lst);
    stack_reply_t r;
    r.data       = d;
    r.has_data   = hd;
    r.status     = st;
    r.error_line = ln;
    r.last       = lst;
    return r;
  endfunction

  // Advance the shadow stack by one word and queue the replies it causes
  task automatic predict_word(logic [2:0] op, logic signed [DATA_W-1:0] val,
                              logic [LINE_W-1:0] ln);
    logic signed [DATA_W-1:0] tmp;
    if (halted) begin
      reply_q.push_back(make_reply('0, 1'b0, ST_HALT, '0, 1'b1));
    end else begin
      case (op)
        REQ_PUSH: begin
          if (depth >= STACK_DEPTH) begin
            overflow_cnt++;
            reply_q.push_back(make_reply('0, 1'b0, ST_FULL, ln, 1'b1));
          end else begin
            stack_mem[depth] = val;
            depth++;
            if (depth > peak_depth) peak_depth = depth;
            reply_q.push_back(make_reply('0, 1'b0, ST_OK, '0, 1'b1));
          end
        end
        REQ_DUMP: begin
          if (depth == 0) begin
            reply_q.push_back(make_reply('0, 1'b0, ST_OK, '0, 1'b1));
          end else begin
            for (int i = depth - 1; i >= 0; i--)
              reply_q.push_back(make_reply(stack_mem[i], 1'b1, ST_OK, '0, i == 0));
          end
        end
        REQ_PEEK: begin
          if (depth == 0) begin
            halted = 1'b1;
            reply_q.push_back(make_reply('0, 1'b0, ST_EMPTY, ln, 1'b1));
          end else begin
            reply_q.push_back(make_reply(stack_mem[depth-1], 1'b1, ST_OK, '0, 1'b1));
          end
        end
        REQ_POP: begin
          if (depth == 0) begin
            halted = 1'b1;
            reply_q.push_back(make_reply('0, 1'b0, ST_EMPTY, ln, 1'b1));
          end else begin
            depth--;
            reply_q.push_back(make_reply('0, 1'b0, ST_OK, '0, 1'b1));
          end
        end
        REQ_SWAP: begin
          // check the count before touching any entry
          if (depth < MIN_SWAP) begin
            halted = 1'b1;
            reply_q.push_back(make_reply('0, 1'b0, ST_SHORT, ln, 1'b1));
          end else begin
            tmp                = stack_mem[depth-1];
            stack_mem[depth-1] = stack_mem[depth-2];
            stack_mem[depth-2] = tmp;
            reply_q.push_back(make_reply('0, 1'b0, ST_OK, '0, 1'b1));
          end
        end
        default: begin
          reply_q.push_back(make_reply('0, 1'b0, ST_OK, '0, 1'b1));
        end
      endcase
    end
    if (halted) halt_seen = 1'b1;
  endtask

  // Compare one result word against the oldest queued reply
  task automatic check_reply();
    stack_reply_t want;
    if (reply_q.size() == 0) begin
      $error("unexpected result: data %0d status %0d last %0b",
             out_mon.data, out_mon.status, out_mon.last);
      fail_count++;
    end else begin
      want = reply_q.pop_front();
      if (out_mon.data !== want.data) begin
        $error("data mismatch: expected %0d, got %0d", want.data, out_mon.data);
        fail_count++;
      end
      if (out_mon.has_data !== want.has_data) begin
        $error("has_data mismatch: expected %0b, got %0b", want.has_data, out_mon.has_data);
        fail_count++;
      end
      if (out_mon.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, out_mon.status);
        fail_count++;
      end
      if (out_mon.error_line !== want.error_line) begin
        $error("error_line mismatch: expected %0h, got %0h",
               want.error_line, out_mon.error_line);
        fail_count++;
      end
      if (out_mon.last !== want.last) begin
        $error("last mismatch: expected %0b, got %0b", want.last, out_mon.last);
        fail_count++;
      end
    end
  endtask

  // Watch both channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      depth  = 0;
      halted = 1'b0;
      reply_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        words_in++;
        predict_word(in_mon.req_type, in_mon.push_value, in_mon.script_line);
      end
      if (out_mon.valid && out_mon.ready) begin
        words_out++;
        check_reply();
      end
    end
    pending = reply_q.size();
  end

endmodule

### sim/lifo_stack_interpreter_ops_tb.sv
module lifo_stack_interpreter_ops_tb;
  import lsi_pkg::*;

  localparam int IDLE_PCT       = 29;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;

  logic clk;
  logic rst_n;

  lsi_in_if  in_ch();
  lsi_out_if out_ch();

  bit no_idle;
  bit hold_req;
  int stim_depth;

  int fail_count;
  int pending;
  int words_in;
  int words_out;
  int peak_depth;
  int overflow_cnt;
  bit halt_seen;

  lifo_stack_interpreter_ops u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lsi_stack_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .words_in     (words_in),
    .words_out    (words_out),
    .peak_depth   (peak_depth),
    .overflow_cnt (overflow_cnt),
    .halt_seen    (halt_seen)
  );

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Drive one word; idle at random first, then hold until accepted
  task automatic send_word(logic [2:0] op, logic signed [DATA_W-1:0] val,
                           logic [LINE_W-1:0] ln);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= op;
    in_ch.push_value  <= val;
    in_ch.script_line <= ln;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == REQ_PUSH && stim_depth < STACK_DEPTH) stim_depth++;
    if (op == REQ_POP && stim_depth > 0) stim_depth--;
  endtask

  // Random mix that never underflows, so the halt stays off
  task automatic send_mixed(int count, int push_pct);
    int         r;
    logic [2:0] op;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < push_pct)      op = REQ_PUSH;
      else if (r < 70)       op = REQ_POP;
      else if (r < 80)       op = REQ_PEEK;
      else if (r < 88)       op = REQ_SWAP;
      else if (r < 94)       op = REQ_DUMP;
      else                   op = REQ_SWAP + 3'($urandom_range(3, 1));
      if ((op == REQ_POP || op == REQ_PEEK) && stim_depth == 0) op = REQ_PUSH;
      if (op == REQ_SWAP && stim_depth < MIN_SWAP) op = REQ_PUSH;
      send_word(op, $urandom, $urandom);
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : sink_side
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $error("timeout: no handshake for %0d cycles, %0d results outstanding",
           WATCHDOG_LIMIT, pending);
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    int halt_kind;
    int keep;
    rst_n             = 1'b0;
    no_idle           = 1'b0;
    hold_req          = 1'b0;
    stim_depth        = 0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_PUSH;
    in_ch.push_value  = '0;
    in_ch.script_line = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every opcode, empty dump, unknown opcodes
    send_word(REQ_DUMP, 32'sd0, 32'd1);
    send_word(REQ_PUSH, 32'sh7fff_ffff, 32'd0);
    send_word(REQ_PUSH, 32'sh8000_0000, 32'hffff_ffff);
    send_word(REQ_PEEK, -32'sd1, 32'h5555_5555);
    send_word(REQ_SWAP, 32'sd0, 32'haaaa_aaaa);
    send_word(REQ_PEEK, 32'sh5555_5555, 32'd7);
    send_word(REQ_DUMP, 32'shaaaa_aaaa, 32'd8);
    send_word(REQ_PUSH, 32'sd0, 32'd9);
    send_word(REQ_PUSH, -32'sd1, 32'd10);
    send_word(REQ_SWAP + 3'd1, 32'sh1234_5678, 32'hffff_fffe);
    send_word(REQ_SWAP + 3'd2, 32'sh7fff_ffff, 32'd12);
    send_word(REQ_SWAP + 3'd3, 32'sh8000_0000, 32'd13);
    send_word(REQ_DUMP, 32'sd0, 32'd14);
    send_word(REQ_POP, 32'sd0, 32'd15);
    send_word(REQ_POP, 32'sd0, 32'd16);
    send_word(REQ_SWAP, 32'sd0, 32'd17);
    send_word(REQ_DUMP, 32'sd0, 32'd18);
    send_word(REQ_POP, 32'sd0, 32'd19);
    send_word(REQ_POP, 32'sd0, 32'd20);
    send_word(REQ_DUMP, 32'sd0, 32'd21);

    // Random mix with idling on both sides
    send_mixed(10, 50);

    // Fill to the top while the result side holds off, then overflow and dump
    hold_req = 1'b1;
    while (stim_depth < STACK_DEPTH) send_word(REQ_PUSH, $urandom, $urandom);
    send_word(REQ_PUSH, $urandom, $urandom);
    send_word(REQ_DUMP, $urandom, $urandom);

    // Halt is sticky and reset comes once: drain with no idling, then pick
    // one halting error per run
    halt_kind = $urandom_range(2);
    keep      = (halt_kind == 2) ? $urandom_range(1) : 0;
    no_idle   = 1'b1;
    while (stim_depth > keep) send_word(REQ_POP, $urandom, $urandom);
    no_idle   = 1'b0;
    case (halt_kind)
      0:       send_word(REQ_PEEK, $urandom, $urandom);
      1:       send_word(REQ_POP, $urandom, $urandom);
      default: send_word(REQ_SWAP, $urandom, $urandom);
    endcase
    repeat (4) send_word(3'($urandom_range(7)), $urandom, $urandom);

    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Drain, then let the block settle
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words in and %0d results out, peak depth %0d of %0d.",
             words_in, words_out, peak_depth, STACK_DEPTH);
    $display("Overflow pushes %0d, halt kind %0d taken %0b, field mismatches %0d.",
             overflow_cnt, halt_kind, halt_seen, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/lsi_pkg.sv
rtl/core/lsi_if.sv
rtl/core/lsi_ram.sv
rtl/core/lsi_front.sv
rtl/core/lsi_back.sv
rtl/core/lifo_stack_interpreter_ops.sv
rtl/core/lsi_checker.sv
sim/lsi_stack_checker.sv
sim/lifo_stack_interpreter_ops_tb.sv
